// File: rtl/aes_pkg.sv
// Shared AES-128 constants, types and round functions.
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int ROUND_W    = 4;
    localparam int BLOCK_W    = 128;
    localparam int HALF_W     = 64;
    localparam int ADDR_W     = 4;

    localparam logic [7:0] GF_POLY = 8'h1b;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [ROUND_W-1:0] t_round;

    // Configuration register indexes; each register sits 8 bytes apart.
    typedef enum logic {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } t_reg_idx;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Round constant for rounds one to ten.
    function automatic logic [7:0] rcon(t_round rnd);
        logic [7:0] rc;
        unique case (rnd)
            4'd1:    rc = 8'h01;
            4'd2:    rc = 8'h02;
            4'd3:    rc = 8'h04;
            4'd4:    rc = 8'h08;
            4'd5:    rc = 8'h10;
            4'd6:    rc = 8'h20;
            4'd7:    rc = 8'h40;
            4'd8:    rc = 8'h80;
            4'd9:    rc = 8'h1b;
            4'd10:   rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    function automatic logic [7:0] xtime(logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    // Byte 0 is the most significant byte of the block.
    function automatic logic [7:0] get_byte(t_block s, int b);
        return s[BLOCK_W-1-8*b -: 8];
    endfunction

    // SubBytes and ShiftRows: row i of column c takes the byte of column c+i.
    function automatic t_block sub_shift(t_block s);
        t_block t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[BLOCK_W-1-8*(4*c+i) -: 8] = SBOX[get_byte(s, 4*((c+i) & 3) + i)];
            end
        end
        return t;
    endfunction

    function automatic t_block mix_columns(t_block t);
        t_block m;
        logic [7:0] a0, a1, a2, a3, all;
        m = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(t, 4*c);
            a1  = get_byte(t, 4*c+1);
            a2  = get_byte(t, 4*c+2);
            a3  = get_byte(t, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            m[BLOCK_W-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            m[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            m[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            m[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return m;
    endfunction

    // One step of the key schedule; each word folds in the freshly updated word before it.
    function automatic t_block next_key(t_block k, t_round rnd);
        logic [31:0] g, w0, w1, w2, w3;
        g  = {SBOX[get_byte(k, 13)] ^ rcon(rnd), SBOX[get_byte(k, 14)],
              SBOX[get_byte(k, 15)], SBOX[get_byte(k, 12)]};
        w0 = k[127:96] ^ g;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// File: rtl/aes_cfg_regs.sv
// Register bank for the two cipher key halves behind the APB-style port.
module aes_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aes_pkg::ADDR_W-1:0]     paddr,
    input  logic [aes_pkg::HALF_W-1:0]     pwdata,
    output logic [aes_pkg::HALF_W-1:0]     prdata,
    output logic                           pready,
    output logic [aes_pkg::HALF_W-1:0]     o_key_high,
    output logic [aes_pkg::HALF_W-1:0]     o_key_low
);

    logic [aes_pkg::HALF_W-1:0] r_key_high;
    logic [aes_pkg::HALF_W-1:0] r_key_low;
    aes_pkg::t_reg_idx          w_idx;
    logic                       w_wr;

    // Registers sit 8 bytes apart; the low address bits are not decoded.
    assign w_idx  = aes_pkg::t_reg_idx'(paddr[3]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                aes_pkg::REG_KEY_HIGH: r_key_high <= pwdata;
                aes_pkg::REG_KEY_LOW:  r_key_low  <= pwdata;
                default:               r_key_low  <= r_key_low;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            aes_pkg::REG_KEY_HIGH: prdata = r_key_high;
            aes_pkg::REG_KEY_LOW:  prdata = r_key_low;
            default:               prdata = '0;
        endcase
    end

    assign o_key_high = r_key_high;
    assign o_key_low  = r_key_low;

endmodule

// File: rtl/aes_round.sv
// One registered cipher round with its own key schedule step.
module aes_round (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aes_pkg::t_round       i_round,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  aes_pkg::t_block       i_state,
    input  aes_pkg::t_block       i_key,
    input  logic                  i_down_ready,
    output logic                  o_valid,
    output aes_pkg::t_block       o_state,
    output aes_pkg::t_block       o_key
);

    logic            r_valid;
    aes_pkg::t_block r_state;
    aes_pkg::t_block r_key;
    aes_pkg::t_block n_state;
    aes_pkg::t_block n_key;
    aes_pkg::t_block w_sub;

    // The stage takes a new request when it is empty or its content moves on.
    assign o_ready = !r_valid || i_down_ready;

    always_comb begin
        w_sub = aes_pkg::sub_shift(i_state);
        n_key = aes_pkg::next_key(i_key, i_round);
        if (i_round == aes_pkg::t_round'(aes_pkg::NUM_ROUNDS)) begin
            n_state = w_sub ^ n_key;
        end else begin
            n_state = aes_pkg::mix_columns(w_sub) ^ n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

// File: rtl/aes128_block_encrypt_core.sv
// AES-128 encryption pipeline: key whitening stage followed by ten round stages.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      i_in_valid / o_in_stall    i_plain_high, i_plain_low
//   out      output     o_out_valid / i_out_stall  o_cipher_high, o_cipher_low
//   cfg      input      APB psel/penable/pready    paddr, pwdata, prdata (64 bits)
//
// A request passes one whitening stage and one stage per round before it leaves. One request
// is accepted per cycle unless the input stalls; each stage holds its own round key, so the rate
// is one block a cycle. Reset clears all stage valid bits and sets both key halves to zero.
// A stall on the output fills empty stages first; the input stalls only when every stage is full.
module aes128_block_encrypt_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [aes_pkg::HALF_W-1:0]         i_plain_high,
    input  logic [aes_pkg::HALF_W-1:0]         i_plain_low,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [aes_pkg::HALF_W-1:0]         o_cipher_high,
    output logic [aes_pkg::HALF_W-1:0]         o_cipher_low,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [aes_pkg::ADDR_W-1:0]         paddr,
    input  logic [aes_pkg::HALF_W-1:0]         pwdata,
    output logic [aes_pkg::HALF_W-1:0]         prdata,
    output logic                               pready
);

    localparam int LAST = aes_pkg::NUM_ROUNDS;

    logic [aes_pkg::HALF_W-1:0] w_key_high;
    logic [aes_pkg::HALF_W-1:0] w_key_low;

    logic            w_valid [0:LAST];
    logic            w_ready [0:LAST];
    aes_pkg::t_block w_state [0:LAST];
    aes_pkg::t_block w_key   [0:LAST-1];

    logic            r_s0_valid;
    aes_pkg::t_block r_s0_state;
    aes_pkg::t_block r_s0_key;

    aes_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_key_high (w_key_high),
        .o_key_low  (w_key_low)
    );

    // Whitening stage: the initial round key is the cipher key itself.
    assign w_ready[0] = !r_s0_valid || w_ready[1];
    assign o_in_stall = !w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_ready[0]) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[0] && i_in_valid) begin
            r_s0_state <= {i_plain_high, i_plain_low} ^ {w_key_high, w_key_low};
            r_s0_key   <= {w_key_high, w_key_low};
        end
    end

    assign w_valid[0] = r_s0_valid;
    assign w_state[0] = r_s0_state;
    assign w_key[0]   = r_s0_key;

    for (genvar g = 1; g < LAST; g++) begin : g_round
        aes_round u_round (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_round      (aes_pkg::t_round'(g)),
            .i_valid      (w_valid[g-1]),
            .o_ready      (w_ready[g]),
            .i_state      (w_state[g-1]),
            .i_key        (w_key[g-1]),
            .i_down_ready (w_ready[g+1]),
            .o_valid      (w_valid[g]),
            .o_state      (w_state[g]),
            .o_key        (w_key[g])
        );
    end

    // The final round skips MixColumns and its stage doubles as the output register.
    aes_round u_last (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_round      (aes_pkg::t_round'(LAST)),
        .i_valid      (w_valid[LAST-1]),
        .o_ready      (w_ready[LAST]),
        .i_state      (w_state[LAST-1]),
        .i_key        (w_key[LAST-1]),
        .i_down_ready (!i_out_stall),
        .o_valid      (w_valid[LAST]),
        .o_state      (w_state[LAST]),
        .o_key        ()
    );

    assign o_out_valid   = w_valid[LAST];
    assign o_cipher_high = w_state[LAST][aes_pkg::BLOCK_W-1:aes_pkg::HALF_W];
    assign o_cipher_low  = w_state[LAST][aes_pkg::HALF_W-1:0];

`ifndef NO_ASSERTIONS
    // The input can only back up when the output is holding a result.
    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output stage could drain");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // No result can appear unless the last round stage is fed.
    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && !w_valid[LAST-1]) |=> !o_out_valid)
        else $error("result appeared without a request in the last round");

    a_whitening_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_valid[0])
        else $error("accepted request missing from whitening stage");
`endif

endmodule

// File: tb/sv/aes128_block_encrypt_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the AES-128 block encryption pipeline.
module aes128_block_encrypt_core_test;

    localparam int HALF_W         = aes_pkg::HALF_W;
    localparam int ADDR_W         = aes_pkg::ADDR_W;
    localparam int PIPE_LATENCY   = 11;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF       = 300;
    localparam int MAX_IDLE       = 16;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BLOCKS   = 140;
    localparam logic [7:0] AES_POLY = 8'h1b;

    typedef struct packed {
        logic [HALF_W-1:0] high;
        logic [HALF_W-1:0] low;
    } t_block_halves;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [HALF_W-1:0] i_plain_high = '0;
    logic [HALF_W-1:0] i_plain_low = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [HALF_W-1:0] o_cipher_high;
    logic [HALF_W-1:0] o_cipher_low;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [HALF_W-1:0] pwdata = '0;
    logic [HALF_W-1:0] prdata;
    logic              pready;

    logic [7:0]        sbox_lut [256];
    logic [HALF_W-1:0] key_high_q = '0;
    logic [HALF_W-1:0] key_low_q = '0;
    t_block_halves     expected_cipher_q [$];

    bit in_idle_en = 1'b1;
    bit out_idle_en = 1'b1;
    int hold_off_cycles = 0;
    int n_errors = 0;
    int n_blocks_sent = 0;
    int n_blocks_checked = 0;
    int n_keys = 0;
    int n_input_stall_cycles = 0;
    int idle_cycles = 0;

    aes128_block_encrypt_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_plain_high (i_plain_high),
        .i_plain_low  (i_plain_low),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cipher_high(o_cipher_high),
        .o_cipher_low (o_cipher_low),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? AES_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] sh;
        acc = '0;
        sh  = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc ^= sh;
            end
            sh = gf_double(sh);
        end
        return acc;
    endfunction

    // The substitution table is derived from the field inverse and the affine map,
    // so the prediction does not share a table with the design.
    function automatic void build_sbox();
        logic [7:0] inv;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            if (x != 0) begin
                inv = 8'h01;
                repeat (254) inv = gf_mul(inv, 8'(x));
            end
            sbox_lut[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                              ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    endfunction

    function automatic t_block_halves aes_encrypt(input t_block_halves key,
                                                  input t_block_halves plain);
        logic [7:0] st [16];
        logic [7:0] rk [16];
        logic [7:0] sh [16];
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3, col_sum;
        t_block_halves res;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127-8*i -: 8];
            st[i] = plain[127-8*i -: 8] ^ rk[i];
        end
        rc = 8'h01;
        for (int r = 0; r < 10; r++) begin
            // Row i of column c comes from column c+i.
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 4; i++) begin
                    sh[4*c+i] = sbox_lut[st[4*((c+i)%4)+i]];
                end
            end
            if (r < 9) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = sh[4*c];
                    a1 = sh[4*c+1];
                    a2 = sh[4*c+2];
                    a3 = sh[4*c+3];
                    col_sum = a0 ^ a1 ^ a2 ^ a3;
                    st[4*c]   = a0 ^ col_sum ^ gf_double(a0 ^ a1);
                    st[4*c+1] = a1 ^ col_sum ^ gf_double(a1 ^ a2);
                    st[4*c+2] = a2 ^ col_sum ^ gf_double(a2 ^ a3);
                    st[4*c+3] = a3 ^ col_sum ^ gf_double(a3 ^ a0);
                end
            end else begin
                st = sh;
            end
            rk[0] ^= sbox_lut[rk[13]] ^ rc;
            rk[1] ^= sbox_lut[rk[14]];
            rk[2] ^= sbox_lut[rk[15]];
            rk[3] ^= sbox_lut[rk[12]];
            for (int j = 4; j < 16; j++) begin
                rk[j] ^= rk[j-4];
            end
            rc = gf_double(rc);
            for (int i = 0; i < 16; i++) begin
                st[i] ^= rk[i];
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127-8*i -: 8] = st[i];
        end
        return res;
    endfunction

    function automatic logic [HALF_W-1:0] rand_half();
        logic [HALF_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = HALF_W'(1) << $urandom_range(0, HALF_W - 1);
            3: v = ~(HALF_W'(1) << $urandom_range(0, HALF_W - 1));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] reg_addr(input aes_pkg::t_reg_idx idx);
        return ADDR_W'(8 * int'(idx));
    endfunction

    task automatic apb_write(input aes_pkg::t_reg_idx idx, input logic [HALF_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == aes_pkg::REG_KEY_HIGH) begin
            key_high_q = value;
        end else begin
            key_low_q = value;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input aes_pkg::t_reg_idx idx, output logic [HALF_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_key_regs();
        logic [HALF_W-1:0] rd;
        apb_read(aes_pkg::REG_KEY_HIGH, rd);
        if (rd !== key_high_q) begin
            $error("key_high readback: expected %h, actual %h", key_high_q, rd);
            n_errors++;
        end
        apb_read(aes_pkg::REG_KEY_LOW, rd);
        if (rd !== key_low_q) begin
            $error("key_low readback: expected %h, actual %h", key_low_q, rd);
            n_errors++;
        end
    endtask

    task automatic set_key(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo);
        apb_write(aes_pkg::REG_KEY_HIGH, hi);
        apb_write(aes_pkg::REG_KEY_LOW, lo);
        check_key_regs();
        n_keys++;
    endtask

    // After a random gap if in_idle_en, offers one request and records its ciphertext once accepted.
    task automatic send_block(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo);
        int gap;
        gap = in_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_plain_high <= hi;
        i_plain_low  <= lo;
        do @(posedge i_clk); while (o_in_stall);
        expected_cipher_q.push_back(aes_encrypt({key_high_q, key_low_q}, {hi, lo}));
        n_blocks_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_cipher_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    task automatic test_reset_key();
        check_key_regs();
        send_block('0, '0);
        send_block('1, '1);
        send_block('0, '1);
        wait_drained();
    endtask

    task automatic test_known_vector();
        t_block_halves got;
        got = aes_encrypt(128'h000102030405060708090a0b0c0d0e0f,
                          128'h00112233445566778899aabbccddeeff);
        if (got !== 128'h69c4e0d86a7b0430d8cdb78070b4c55a) begin
            $error("predictor known answer: expected %h, actual %h",
                   128'h69c4e0d86a7b0430d8cdb78070b4c55a, got);
            n_errors++;
        end
        set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        wait_drained();
    endtask

    task automatic test_directed_extremes();
        set_key('1, '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h1, 64'h8000000000000000);
        send_block(64'h8000000000000000, 64'h1);
        send_block(64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a);
        send_block(64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5);
        wait_drained();
        set_key(64'h8000000000000001, 64'h0123456789abcdef);
        send_block('0, '0);
        send_block('1, '0);
        send_block(64'hfedcba9876543210, 64'h0f0f0f0f0f0f0f0f);
        wait_drained();
        // Only the low half changes: the old high half must still be in use.
        apb_write(aes_pkg::REG_KEY_LOW, 64'h0);
        check_key_regs();
        send_block(64'h0123456789abcdef, 64'hf0f0f0f0f0f0f0f0);
        send_block('1, '1);
        wait_drained();
    endtask

    // The receiver holds off while the sender keeps offering, so the pipeline fills up.
    task automatic test_backpressure();
        set_key({$urandom, $urandom}, {$urandom, $urandom});
        in_idle_en = 1'b0;
        hold_off_cycles = HOLD_OFF;
        repeat (48) send_block(rand_half(), rand_half());
        wait_drained();
        in_idle_en = 1'b1;
    endtask

    task automatic test_random();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_key('1, '1);
                1: set_key('0, '0);
                2: set_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
                default: set_key({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            in_idle_en  = (p != 3);
            out_idle_en = (p != 3) && (p != 6);
            repeat (PHASE_BLOCKS) send_block(rand_half(), rand_half());
            wait_drained();
        end
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
    endtask

    // Receiver: a random stall before each result if out_idle_en, or a long hold-off on request.
    initial begin
        int n;
        forever begin
            if (hold_off_cycles > 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                n = out_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
            end
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_block_halves exp_blk;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_cipher_q.size() == 0) begin
                $error("unexpected result: cipher_high %h, cipher_low %h",
                       o_cipher_high, o_cipher_low);
                n_errors++;
            end else begin
                exp_blk = expected_cipher_q.pop_front();
                if (o_cipher_high !== exp_blk.high) begin
                    $error("cipher_high: expected %h, actual %h", exp_blk.high, o_cipher_high);
                    n_errors++;
                end
                if (o_cipher_low !== exp_blk.low) begin
                    $error("cipher_low: expected %h, actual %h", exp_blk.low, o_cipher_low);
                    n_errors++;
                end
                n_blocks_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_in_valid && o_in_stall) begin
            n_input_stall_cycles++;
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        build_sbox();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_key();
        test_known_vector();
        test_directed_extremes();
        test_backpressure();
        test_random();

        $display("tb: %0d blocks encrypted under %0d keys, %0d results checked",
                 n_blocks_sent, n_keys, n_blocks_checked);
        $display("tb: input held back for %0d cycles by a full pipeline, %0d mismatches",
                 n_input_stall_cycles, n_errors);
        if (n_errors == 0 && expected_cipher_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/aes_pkg.sv
rtl/aes_cfg_regs.sv
rtl/aes_round.sv
rtl/aes128_block_encrypt_core.sv
tb/sv/aes128_block_encrypt_core_test.sv
